[src/rm2q_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion pipeline.
// Used by every module in src; no dependencies of its own.
package rm2q_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ELEM_W        = 18;
    // Sum or difference of two matrix elements.
    localparam int NUM_W         = ELEM_W + 1;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    // Carried alongside the square root: branch, invalid flag and the three
    // off-diagonal numerators, in component order with the dominant one skipped.
    typedef struct packed {
        branch_t                   br;
        logic                      inv;
        logic [2:0][NUM_W-1:0]     num;
    } side_t;

endpackage

[src/rm2q_prep.sv]
// Front stage: trace, branch selection, radicand and numerators, one register.
// Depends on rm2q_pkg.
module rm2q_prep #(
    parameter int FRAC_BITS = rm2q_pkg::FRAC_BITS_DEF,
    parameter int RAD_W     = 22,
    parameter int SQ_IN_W   = 35
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_00,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_01,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_02,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_10,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_11,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_12,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_20,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_21,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_22,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [SQ_IN_W-1:0]                 rad_sh,
    output rm2q_pkg::side_t                    side
);

    localparam int NW = rm2q_pkg::NUM_W;
    localparam logic signed [RAD_W-1:0] ONE = {{(RAD_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic                        valid_reg;
    logic                        load;
    logic [SQ_IN_W-1:0]          rad_sh_reg;
    logic [SQ_IN_W-1:0]          rad_sh_next;
    rm2q_pkg::side_t             side_reg;
    rm2q_pkg::side_t             side_next;

    logic signed [RAD_W-1:0]     r00;
    logic signed [RAD_W-1:0]     r11;
    logic signed [RAD_W-1:0]     r22;
    logic signed [RAD_W-1:0]     trace;
    logic signed [RAD_W-1:0]     rad;
    logic signed [NW-1:0]        d21_12;
    logic signed [NW-1:0]        d02_20;
    logic signed [NW-1:0]        d10_01;
    logic signed [NW-1:0]        s01_10;
    logic signed [NW-1:0]        s02_20;
    logic signed [NW-1:0]        s12_21;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    always_comb
    begin
        r00    = RAD_W'(elem_00);
        r11    = RAD_W'(elem_11);
        r22    = RAD_W'(elem_22);
        trace  = r00 + r11 + r22;
        d21_12 = NW'(elem_21) - NW'(elem_12);
        d02_20 = NW'(elem_02) - NW'(elem_20);
        d10_01 = NW'(elem_10) - NW'(elem_01);
        s01_10 = NW'(elem_01) + NW'(elem_10);
        s02_20 = NW'(elem_02) + NW'(elem_20);
        s12_21 = NW'(elem_12) + NW'(elem_21);

        priority if (trace > 0)
        begin
            side_next.br = rm2q_pkg::BR_TRACE;
            rad          = ONE + trace;
            side_next.num = {d10_01, d02_20, d21_12};
        end
        else if (r00 > r11 && r00 > r22)
        begin
            side_next.br = rm2q_pkg::BR_X;
            rad          = ONE + r00 - r11 - r22;
            side_next.num = {s02_20, s01_10, d21_12};
        end
        else if (r11 > r22)
        begin
            side_next.br = rm2q_pkg::BR_Y;
            rad          = ONE + r11 - r00 - r22;
            side_next.num = {s12_21, s01_10, d02_20};
        end
        else
        begin
            side_next.br = rm2q_pkg::BR_Z;
            rad          = ONE + r22 - r00 - r11;
            side_next.num = {s12_21, s02_20, d10_01};
        end

        side_next.inv = !(rad > 0);
        if (side_next.inv)
            rad_sh_next = '0;
        else
            rad_sh_next = SQ_IN_W'(rad[RAD_W-2:0]) << (FRAC_BITS - 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            rad_sh_reg <= rad_sh_next;
            side_reg   <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign rad_sh    = rad_sh_reg;
    assign side      = side_reg;

endmodule

[src/rm2q_sqrt.sv]
// Pipelined integer square root, one root bit per stage, side data carried along.
// Depends on rm2q_pkg.
module rm2q_sqrt #(
    parameter int IN_W   = 35,
    parameter int ROOT_W = 18
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IN_W-1:0]       rad,
    input  rm2q_pkg::side_t       side_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ROOT_W-1:0]     root,
    output rm2q_pkg::side_t       side_out
);

    localparam int TW = IN_W + 2;

    logic [IN_W-1:0]     rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    rm2q_pkg::side_t     side_reg [ROOT_W];
    logic [ROOT_W-1:0]   valid_reg;
    logic [ROOT_W-1:0]   load;

    genvar s;
    generate
        for (s = 0; s < ROOT_W; s++)
        begin : g_stage
            localparam int B = ROOT_W - 1 - s;

            logic [IN_W-1:0]    rem_prev;
            logic [ROOT_W-1:0]  root_prev;
            rm2q_pkg::side_t    side_prev;
            logic               valid_prev;
            logic [TW-1:0]      trial;
            logic               take;
            logic [IN_W-1:0]    rem_next;
            logic [ROOT_W-1:0]  root_next;

            if (s == 0)
            begin : g_first
                assign rem_prev   = rad;
                assign root_prev  = '0;
                assign side_prev  = side_in;
                assign valid_prev = in_valid;
            end
            else
            begin : g_rest
                assign rem_prev   = rem_reg[s-1];
                assign root_prev  = root_reg[s-1];
                assign side_prev  = side_reg[s-1];
                assign valid_prev = valid_reg[s-1];
            end

            if (s == ROOT_W - 1)
            begin : g_last_load
                assign load[s] = !valid_reg[s] || out_ready;
            end
            else
            begin : g_mid_load
                assign load[s] = !valid_reg[s] || load[s+1];
            end

            // Try setting this root bit: (root + 2^B)^2 - root^2 against the remainder.
            always_comb
            begin
                trial = (TW'(root_prev) << (B + 1)) | (TW'(1) << (2 * B));
                take  = TW'(rem_prev) >= trial;
                if (take)
                begin
                    rem_next  = IN_W'(TW'(rem_prev) - trial);
                    root_next = root_prev | (ROOT_W'(1) << B);
                end
                else
                begin
                    rem_next  = rem_prev;
                    root_next = root_prev;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else if (load[s])
                    valid_reg[s] <= valid_prev;
            end

            always_ff @(posedge clk)
            begin
                if (load[s] && valid_prev)
                begin
                    rem_reg[s]  <= rem_next;
                    root_reg[s] <= root_next;
                    side_reg[s] <= side_prev;
                end
            end
        end
    endgenerate

    assign in_ready  = load[0];
    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

[src/rm2q_div.sv]
// Three-lane pipelined restoring divider: |num| * 2^(FRAC_BITS-2) / h, one bit per stage.
// Depends on rm2q_pkg.
module rm2q_div #(
    parameter int FRAC_BITS = rm2q_pkg::FRAC_BITS_DEF,
    parameter int ROOT_W    = 18
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ROOT_W-1:0]        h,
    input  rm2q_pkg::side_t          side,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ROOT_W-1:0]        h_out,
    output logic [2:0][FRAC_BITS:0]  quo,
    output logic [2:0]               sat,
    output logic [2:0]               neg,
    output rm2q_pkg::branch_t        br,
    output logic                     inv
);

    localparam int MAG_W = rm2q_pkg::NUM_W;
    localparam int DV_W  = MAG_W + FRAC_BITS - 2;
    localparam int NS    = FRAC_BITS + 2;
    localparam int C0_W  = ((MAG_W > ROOT_W + 3) ? MAG_W : ROOT_W + 3) + 1;
    localparam int CW    = ((DV_W > ROOT_W + FRAC_BITS) ? DV_W : ROOT_W + FRAC_BITS) + 1;

    logic [2:0][DV_W-1:0]      rem_reg [NS];
    logic [2:0][FRAC_BITS:0]   quo_reg [NS];
    logic [2:0]                sat_reg [NS];
    logic [2:0]                neg_reg [NS];
    logic [ROOT_W-1:0]         h_reg   [NS];
    rm2q_pkg::branch_t         br_reg  [NS];
    logic                      inv_reg [NS];
    logic [NS-1:0]             valid_reg;
    logic [NS-1:0]             load;

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_stage
            logic [2:0][DV_W-1:0]     rem_next;
            logic [2:0][FRAC_BITS:0]  quo_next;
            logic [2:0]               sat_next;
            logic [2:0]               neg_next;
            logic [ROOT_W-1:0]        h_next;
            rm2q_pkg::branch_t        br_next;
            logic                     inv_next;
            logic                     valid_prev;

            if (s == NS - 1)
            begin : g_last_load
                assign load[s] = !valid_reg[s] || out_ready;
            end
            else
            begin : g_mid_load
                assign load[s] = !valid_reg[s] || load[s+1];
            end

            if (s == 0)
            begin : g_first
                logic [MAG_W-1:0] mag [3];

                assign valid_prev = in_valid;

                // Split sign and magnitude; a quotient of 2^(FRAC_BITS+1) or more
                // (|num| >= 8h) is flagged here so the bit stages never overflow.
                always_comb
                begin
                    h_next   = h;
                    br_next  = side.br;
                    inv_next = side.inv;
                    for (int k = 0; k < 3; k++)
                    begin
                        neg_next[k] = side.num[k][MAG_W-1];
                        mag[k]      = neg_next[k] ? (MAG_W'(0) - side.num[k]) : side.num[k];
                        sat_next[k] = C0_W'(mag[k]) >= (C0_W'(h) << 3);
                        rem_next[k] = DV_W'(mag[k]) << (FRAC_BITS - 2);
                        quo_next[k] = '0;
                    end
                end
            end
            else
            begin : g_bit
                localparam int I = FRAC_BITS + 1 - s;

                logic [CW-1:0] dv;

                assign valid_prev = valid_reg[s-1];

                always_comb
                begin
                    h_next   = h_reg[s-1];
                    br_next  = br_reg[s-1];
                    inv_next = inv_reg[s-1];
                    sat_next = sat_reg[s-1];
                    neg_next = neg_reg[s-1];
                    dv       = CW'(h_reg[s-1]) << I;
                    for (int k = 0; k < 3; k++)
                    begin
                        if (CW'(rem_reg[s-1][k]) >= dv)
                        begin
                            rem_next[k] = DV_W'(CW'(rem_reg[s-1][k]) - dv);
                            quo_next[k] = quo_reg[s-1][k] | ((FRAC_BITS + 1)'(1) << I);
                        end
                        else
                        begin
                            rem_next[k] = rem_reg[s-1][k];
                            quo_next[k] = quo_reg[s-1][k];
                        end
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else if (load[s])
                    valid_reg[s] <= valid_prev;
            end

            always_ff @(posedge clk)
            begin
                if (load[s] && valid_prev)
                begin
                    rem_reg[s] <= rem_next;
                    quo_reg[s] <= quo_next;
                    sat_reg[s] <= sat_next;
                    neg_reg[s] <= neg_next;
                    h_reg[s]   <= h_next;
                    br_reg[s]  <= br_next;
                    inv_reg[s] <= inv_next;
                end
            end
        end
    endgenerate

    assign in_ready  = load[0];
    assign out_valid = valid_reg[NS-1];
    assign h_out     = h_reg[NS-1];
    assign quo       = quo_reg[NS-1];
    assign sat       = sat_reg[NS-1];
    assign neg       = neg_reg[NS-1];
    assign br        = br_reg[NS-1];
    assign inv       = inv_reg[NS-1];

endmodule

[src/rotation_matrix_to_quaternion.sv]
// Stages: a front stage, one square-root stage per root bit, a divider stage per
// quotient bit plus one, and the output stage. Throughput: one matrix per cycle
// while out_ready is high; every stage advances on its own, so bubbles close up.
// Reset: rst_n clears all stage valid bits asynchronously; data registers are not reset.
// Depends on rm2q_pkg, rm2q_prep, rm2q_sqrt and rm2q_div.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rm2q_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_00,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_01,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_02,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_10,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_11,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_12,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_20,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_21,
    input  logic signed [rm2q_pkg::ELEM_W-1:0] elem_22,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [rm2q_pkg::ELEM_W-1:0] quat_w,
    output logic signed [rm2q_pkg::ELEM_W-1:0] quat_x,
    output logic signed [rm2q_pkg::ELEM_W-1:0] quat_y,
    output logic signed [rm2q_pkg::ELEM_W-1:0] quat_z,
    output logic [1:0]                         branch_used,
    output logic                               invalid
);

    localparam int OW      = rm2q_pkg::ELEM_W;
    localparam int RAD_W   = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3;
    localparam int SQ_IN_W = RAD_W - 1 + FRAC_BITS - 2;
    localparam int ROOT_W  = (SQ_IN_W + 1) / 2;
    localparam int VW      = ((FRAC_BITS + 2) > OW) ? FRAC_BITS + 2 : OW;
    localparam int EW      = ROOT_W + VW;
    localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;

    logic                     prep_valid;
    logic                     prep_ready;
    logic [SQ_IN_W-1:0]       prep_rad;
    rm2q_pkg::side_t          prep_side;

    logic                     sq_valid;
    logic                     sq_ready;
    logic [ROOT_W-1:0]        sq_root;
    rm2q_pkg::side_t          sq_side;

    logic                     dv_valid;
    logic                     dv_ready;
    logic [ROOT_W-1:0]        dv_h;
    logic [2:0][FRAC_BITS:0]  dv_quo;
    logic [2:0]               dv_sat;
    logic [2:0]               dv_neg;
    rm2q_pkg::branch_t        dv_br;
    logic                     dv_inv;

    logic                     valid_reg;
    logic [OW-1:0]            quat_w_reg;
    logic [OW-1:0]            quat_x_reg;
    logic [OW-1:0]            quat_y_reg;
    logic [OW-1:0]            quat_z_reg;
    rm2q_pkg::branch_t        br_reg;
    logic                     inv_reg;
    logic [OW-1:0]            quat_w_next;
    logic [OW-1:0]            quat_x_next;
    logic [OW-1:0]            quat_y_next;
    logic [OW-1:0]            quat_z_next;

    logic [VW-1:0]            dom;
    logic [VW-1:0]            lane [3];
    logic [FRAC_BITS:0]       lmag;

    rm2q_prep #(
        .FRAC_BITS (FRAC_BITS),
        .RAD_W     (RAD_W),
        .SQ_IN_W   (SQ_IN_W)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .elem_00   (elem_00),
        .elem_01   (elem_01),
        .elem_02   (elem_02),
        .elem_10   (elem_10),
        .elem_11   (elem_11),
        .elem_12   (elem_12),
        .elem_20   (elem_20),
        .elem_21   (elem_21),
        .elem_22   (elem_22),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .rad_sh    (prep_rad),
        .side      (prep_side)
    );

    rm2q_sqrt #(
        .IN_W   (SQ_IN_W),
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .rad       (prep_rad),
        .side_in   (prep_side),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    rm2q_div #(
        .FRAC_BITS (FRAC_BITS),
        .ROOT_W    (ROOT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .h         (sq_root),
        .side      (sq_side),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .h_out     (dv_h),
        .quo       (dv_quo),
        .sat       (dv_sat),
        .neg       (dv_neg),
        .br        (dv_br),
        .inv       (dv_inv)
    );

    assign dv_ready = !valid_reg || out_ready;

    // Saturate to 1.0, apply signs, place lanes around the dominant one; zero if invalid.
    always_comb
    begin
        lmag = '0;
        if (EW'(dv_h) > EW'(ONE_V))
            dom = ONE_V;
        else
            dom = VW'(dv_h);
        for (int k = 0; k < 3; k++)
        begin
            if (dv_sat[k] || (dv_quo[k] > (FRAC_BITS + 1)'(ONE_V)))
                lmag = (FRAC_BITS + 1)'(ONE_V);
            else
                lmag = dv_quo[k];
            lane[k] = dv_neg[k] ? (VW'(0) - VW'(lmag)) : VW'(lmag);
        end

        unique case (dv_br)
            rm2q_pkg::BR_TRACE:
            begin
                quat_w_next = dom[OW-1:0];
                quat_x_next = lane[0][OW-1:0];
                quat_y_next = lane[1][OW-1:0];
                quat_z_next = lane[2][OW-1:0];
            end
            rm2q_pkg::BR_X:
            begin
                quat_w_next = lane[0][OW-1:0];
                quat_x_next = dom[OW-1:0];
                quat_y_next = lane[1][OW-1:0];
                quat_z_next = lane[2][OW-1:0];
            end
            rm2q_pkg::BR_Y:
            begin
                quat_w_next = lane[0][OW-1:0];
                quat_x_next = lane[1][OW-1:0];
                quat_y_next = dom[OW-1:0];
                quat_z_next = lane[2][OW-1:0];
            end
            default:
            begin
                quat_w_next = lane[0][OW-1:0];
                quat_x_next = lane[1][OW-1:0];
                quat_y_next = lane[2][OW-1:0];
                quat_z_next = dom[OW-1:0];
            end
        endcase

        if (dv_inv)
        begin
            quat_w_next = '0;
            quat_x_next = '0;
            quat_y_next = '0;
            quat_z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (dv_ready)
            valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready && dv_valid)
        begin
            quat_w_reg <= quat_w_next;
            quat_x_reg <= quat_x_next;
            quat_y_reg <= quat_y_next;
            quat_z_reg <= quat_z_next;
            br_reg     <= dv_br;
            inv_reg    <= dv_inv;
        end
    end

    assign out_valid   = valid_reg;
    assign quat_w      = quat_w_reg;
    assign quat_x      = quat_x_reg;
    assign quat_y      = quat_y_reg;
    assign quat_z      = quat_z_reg;
    assign branch_used = br_reg;
    assign invalid     = inv_reg;

    // A rejected radicand must come out as an all-zero quaternion.
    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && inv_reg |->
            quat_w_reg == '0 && quat_x_reg == '0 && quat_y_reg == '0 && quat_z_reg == '0)
        else $error("invalid result with nonzero quaternion");

    // The trace branch radicand is one plus a positive trace, never rejected.
    a_trace_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && br_reg == rm2q_pkg::BR_TRACE |-> !inv_reg)
        else $error("trace branch flagged invalid");

    // A positive radicand is at least 2^(FRAC_BITS-2), so its root cannot be zero.
    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid && !sq_side.inv |-> sq_root != '0)
        else $error("zero root for accepted radicand");

    // The front stage only holds a request while the square root stage is full.
    a_prep_hold: assert property (@(posedge clk) disable iff (!rst_n)
        prep_valid && !prep_ready |=> prep_valid)
        else $error("front stage dropped a stalled request");

endmodule

[tb/sv/rotation_matrix_to_quaternion_tb.sv]
`timescale 1ns / 1ps
// Testbench for rotation_matrix_to_quaternion: drives matrices, predicts each quaternion
// in SystemVerilog and checks every result in order. Depends on rm2q_pkg and the block.
module rotation_matrix_to_quaternion_tb;

    localparam int FB = rm2q_pkg::FRAC_BITS_DEF;
    localparam longint QONE = 64'sd1 << FB;

    typedef logic signed [rm2q_pkg::ELEM_W-1:0] elem_t;
    typedef struct {
        elem_t             w, x, y, z;
        rm2q_pkg::branch_t br;
        logic              inv;
    } quat_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    elem_t e00, e01, e02, e10, e11, e12, e20, e21, e22;
    elem_t quat_w, quat_x, quat_y, quat_z;
    logic [1:0] branch_used;
    logic invalid;

    quat_t expected_q[$];
    int errors = 0;
    bit hold_output = 0;
    bit long_stalls = 1;

    rotation_matrix_to_quaternion dut (
        .clk, .rst_n, .in_valid, .in_ready,
        .elem_00(e00), .elem_01(e01), .elem_02(e02),
        .elem_10(e10), .elem_11(e11), .elem_12(e12),
        .elem_20(e20), .elem_21(e21), .elem_22(e22),
        .out_valid, .out_ready, .quat_w, .quat_x, .quat_y, .quat_z,
        .branch_used, .invalid
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > QONE) return QONE;
        if (v < -QONE) return -QONE;
        return v;
    endfunction

    function automatic longint scaled_ratio(longint num, longint h);
        longint unsigned mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag << FB) / (h * 4);
        if (q > QONE) q = QONE + 1;
        return clamp_one(num < 0 ? -longint'(q) : longint'(q));
    endfunction

    function automatic quat_t predict_quat(elem_t m[9]);
        longint r[9], tr, rad, n[4], q[4], h;
        quat_t res;
        foreach (r[i]) r[i] = longint'(m[i]);
        n = '{0, 0, 0, 0};
        q = '{0, 0, 0, 0};
        tr = r[0] + r[4] + r[8];
        if (tr > 0)
        begin
            res.br = rm2q_pkg::BR_TRACE; rad = QONE + tr;
            n[1] = r[7] - r[5]; n[2] = r[2] - r[6]; n[3] = r[3] - r[1];
        end
        else if (r[0] > r[4] && r[0] > r[8])
        begin
            res.br = rm2q_pkg::BR_X; rad = QONE + r[0] - r[4] - r[8];
            n[0] = r[7] - r[5]; n[2] = r[1] + r[3]; n[3] = r[2] + r[6];
        end
        else if (r[4] > r[8])
        begin
            res.br = rm2q_pkg::BR_Y; rad = QONE + r[4] - r[0] - r[8];
            n[0] = r[2] - r[6]; n[1] = r[1] + r[3]; n[3] = r[5] + r[7];
        end
        else
        begin
            res.br = rm2q_pkg::BR_Z; rad = QONE + r[8] - r[0] - r[4];
            n[0] = r[3] - r[1]; n[1] = r[2] + r[6]; n[2] = r[5] + r[7];
        end
        res.inv = (rad <= 0);
        if (!res.inv)
        begin
            h = int_sqrt(rad << (FB - 2));
            for (int k = 0; k < 4; k++)
                q[k] = (k == int'(res.br)) ? clamp_one(h) : scaled_ratio(n[k], h);
        end
        res.w = elem_t'(q[0]);
        res.x = elem_t'(q[1]);
        res.y = elem_t'(q[2]);
        res.z = elem_t'(q[3]);
        return res;
    endfunction

    function automatic int gap_len();
        if (!long_stalls) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Valid stays high across back-to-back requests; drop it only for a gap.
    task automatic send_matrix(elem_t m[9]);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        e00 <= m[0]; e01 <= m[1]; e02 <= m[2];
        e10 <= m[3]; e11 <= m[4]; e12 <= m[5];
        e20 <= m[6]; e21 <= m[7]; e22 <= m[8];
        in_valid <= 1;
        expected_q.push_back(predict_quat(m));
        do @(posedge clk); while (!in_ready);
    endtask

    // Result checker: sample on the edge, stall at random.
    always @(posedge clk)
    begin
        quat_t exp_q;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no request pending");
                errors++;
            end
            else
            begin
                exp_q = expected_q.pop_front();
                if (quat_w !== exp_q.w)
                begin $error("quat_w exp %0d got %0d", exp_q.w, quat_w); errors++; end
                if (quat_x !== exp_q.x)
                begin $error("quat_x exp %0d got %0d", exp_q.x, quat_x); errors++; end
                if (quat_y !== exp_q.y)
                begin $error("quat_y exp %0d got %0d", exp_q.y, quat_y); errors++; end
                if (quat_z !== exp_q.z)
                begin $error("quat_z exp %0d got %0d", exp_q.z, quat_z); errors++; end
                if (branch_used !== exp_q.br)
                begin $error("branch_used exp %0d got %0d", exp_q.br, branch_used); errors++; end
                if (invalid !== exp_q.inv)
                begin $error("invalid exp %0d got %0d", exp_q.inv, invalid); errors++; end
            end
        end
        out_ready <= !hold_output && (gap_len() == 0);
    end

    task automatic wait_drained();
        in_valid <= 0;
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    function automatic elem_t rand_elem();
        unique case ($urandom_range(0, 9))
            0: return elem_t'($urandom);               // any 18-bit pattern
            1: return $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
            2: return '0;
            default: return elem_t'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    // Orthonormal-ish matrix from a random quaternion, for realistic branches.
    function automatic void rot_from_quat(output elem_t m[9]);
        real a, b, c, d, nrm;
        real f[9];
        a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
        c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
        nrm = $sqrt(a*a + b*b + c*c + d*d) + 1e-9;
        a /= nrm; b /= nrm; c /= nrm; d /= nrm;
        f = '{1-2*(c*c+d*d), 2*(b*c-a*d), 2*(b*d+a*c),
              2*(b*c+a*d), 1-2*(b*b+d*d), 2*(c*d-a*b),
              2*(b*d-a*c), 2*(c*d+a*b), 1-2*(b*b+c*c)};
        foreach (m[i]) m[i] = elem_t'($rtoi(f[i] * 65536.0));
    endfunction

    task automatic test_directed();
        elem_t m[9];
        m = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536}; send_matrix(m);  // identity
        m = '{65536, 0, 0, 0, -65536, 0, 0, 0, -65536}; send_matrix(m); // x dominant
        m = '{-65536, 0, 0, 0, 65536, 0, 0, 0, -65536}; send_matrix(m); // y dominant
        m = '{-65536, 0, 0, 0, -65536, 0, 0, 0, 65536}; send_matrix(m); // z dominant
        m = '{-65536, 0, 0, 0, -65536, 0, 0, 0, -65536}; send_matrix(m); // z branch
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);   // ties fall to z
        m = '{-131072, 131071, -131072, 131071, -131072, 131071, -131072, 131071, -131072};
        send_matrix(m);                                     // extreme patterns
        m = '{131071, -131072, 131071, -131072, 131071, -131072, 131071, -131072, 131071};
        send_matrix(m);                                     // saturation
        m = '{100, 65536, -65536, -65536, 100, 65536, 65536, -65536, -300};
        send_matrix(m);                                     // y branch
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 1}; send_matrix(m);   // smallest positive trace
        m = '{-5, 3, 0, 0, -5, 0, 0, 0, -5}; send_matrix(m);
        wait_drained();
    endtask

    task automatic test_random(int count);
        elem_t m[9];
        repeat (count)
        begin
            if ($urandom_range(0, 3) != 0) rot_from_quat(m);
            else foreach (m[i]) m[i] = rand_elem();
            send_matrix(m);
        end
    endtask

    task automatic test_backpressure();
        elem_t m[9];
        fork
            begin
                hold_output = 1;
                repeat (120) @(posedge clk);
                hold_output = 0;
            end
            begin
                long_stalls = 0;
                repeat (80)
                begin
                    rot_from_quat(m);
                    send_matrix(m);
                end
                long_stalls = 1;
                wait_drained();
            end
        join
    endtask

    initial
    begin
        rst_n = 0; in_valid = 0; out_ready = 0;
        {e00, e01, e02, e10, e11, e12, e20, e21, e22} = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_random(300);
        test_backpressure();
        test_random(260);
        wait_drained();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("PASS rotation_matrix_to_quaternion");
        else
            $display("FAIL rotation_matrix_to_quaternion");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL rotation_matrix_to_quaternion");
        $finish;
    end
endmodule

[rotation_matrix_to_quaternion.f]
src/rm2q_pkg.sv
src/rm2q_prep.sv
src/rm2q_sqrt.sv
src/rm2q_div.sv
src/rotation_matrix_to_quaternion.sv
tb/sv/rotation_matrix_to_quaternion_tb.sv
